>>> rtl/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types, constants and tables of the UV sphere tessellator.
// ----------------------------------------------------------------------------
package uvs_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STEPS  = 24;
    localparam int BUF_DEPTH     = 8;
    localparam int BUF_AW        = $clog2(BUF_DEPTH);
    localparam int MAX_DIVISIONS = 256;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [16:0] COORD_MAX   = 17'sd65535;

    typedef enum logic [1:0] {
        KIND_FIRST,
        KIND_LAST,
        KIND_MID
    } kind_t;

    // One angle travelling down the rotation chain
    typedef struct packed {
        logic               valid;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [31:0] z;
        logic [1:0]         quad;
        logic [1:0]         slot;
        kind_t              kind;
    } cord_t;

    // Sine/cosine write into the cell buffer
    typedef struct packed {
        logic               we;
        logic [1:0]         slot;
        kind_t              kind;
        logic signed [16:0] s;
        logic signed [16:0] c;
    } sc_wr_t;

    // Arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:    r = 32'd536870912;
                5'd1:    r = 32'd316933411;
                5'd2:    r = 32'd167458907;
                5'd3:    r = 32'd85004756;
                5'd4:    r = 32'd42667331;
                5'd5:    r = 32'd21354465;
                5'd6:    r = 32'd10679838;
                5'd7:    r = 32'd5340245;
                5'd8:    r = 32'd2670163;
                5'd9:    r = 32'd1335087;
                5'd10:   r = 32'd667544;
                5'd11:   r = 32'd333772;
                5'd12:   r = 32'd166886;
                5'd13:   r = 32'd83443;
                5'd14:   r = 32'd41722;
                5'd15:   r = 32'd20861;
                5'd16:   r = 32'd10430;
                5'd17:   r = 32'd5215;
                5'd18:   r = 32'd2608;
                5'd19:   r = 32'd1304;
                5'd20:   r = 32'd652;
                5'd21:   r = 32'd326;
                5'd22:   r = 32'd163;
                5'd23:   r = 32'd81;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

    // Vertex offsets {dp, dq} of vertex k within a cell
    function automatic logic [1:0] pat_off(input kind_t kind, input logic [2:0] k);
        logic [1:0] r;
        begin
            r = 2'b00;
            unique case (kind)
                KIND_FIRST:
                begin
                    case (k)
                        3'd0:    r = 2'b11;
                        3'd1:    r = 2'b00;
                        default: r = 2'b10;
                    endcase
                end
                KIND_LAST:
                begin
                    case (k)
                        3'd0:    r = 2'b01;
                        3'd1:    r = 2'b00;
                        default: r = 2'b11;
                    endcase
                end
                default:
                begin
                    case (k)
                        3'd0:    r = 2'b11;
                        3'd1:    r = 2'b00;
                        3'd2:    r = 2'b10;
                        3'd3:    r = 2'b01;
                        3'd4:    r = 2'b00;
                        default: r = 2'b11;
                    endcase
                end
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [16:0] sat_coord(input logic signed [35:0] v);
        logic signed [16:0] r;
        begin
            if (v > 36'sd65535)
                r = COORD_MAX;
            else if (v < -36'sd65535)
                r = -COORD_MAX;
            else
                r = v[16:0];
            return r;
        end
    endfunction

endpackage

>>> rtl/uvs_cordic_cell.sv
// ----------------------------------------------------------------------------
// uvs_cordic_cell
// One rotation-mode CORDIC iteration, registered toward the next cell.
// ----------------------------------------------------------------------------
module uvs_cordic_cell
    import uvs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [4:0] stage,
    input  cord_t      cin,
    output cord_t      cout
);

    cord_t              cout_reg;
    cord_t              cout_next;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [31:0] da;

    always_comb
    begin
        dx        = cin.y >>> stage;
        dy        = cin.x >>> stage;
        da        = $signed(atan_turn(stage));
        cout_next = cin;
        if (!cin.z[31])
        begin
            cout_next.x = cin.x - dx;
            cout_next.y = cin.y + dy;
            cout_next.z = cin.z - da;
        end
        else
        begin
            cout_next.x = cin.x + dx;
            cout_next.y = cin.y - dy;
            cout_next.z = cin.z + da;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cout_reg <= '0;
        else
            cout_reg <= cout_next;
    end

    assign cout = cout_reg;

endmodule

>>> rtl/uvs_vertex_unit.sv
// ----------------------------------------------------------------------------
// uvs_vertex_unit
// Cell buffer of sine/cosine rows, vertex sequencer and scaling multipliers.
// ----------------------------------------------------------------------------
module uvs_vertex_unit
    import uvs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sc_wr_t      wr,
    input  logic [15:0] radius,
    output logic        taken,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // x_coord[16:0], y_coord[33:17], z_coord[50:34], zero pad
    output logic        m_tlast
);

    logic signed [16:0] mem_s [BUF_DEPTH][4];
    logic signed [16:0] mem_c [BUF_DEPTH][4];
    kind_t              mem_kind [BUF_DEPTH];

    logic [BUF_AW:0]    wptr_reg, wptr_next;
    logic [BUF_AW:0]    rptr_reg, rptr_next;
    logic               active_reg, active_next;
    logic [2:0]         k_reg, k_next;

    logic signed [16:0] row_s_reg [4];
    logic signed [16:0] row_c_reg [4];
    kind_t              row_kind_reg;

    logic               v1_reg, v2_reg, out_valid_reg;
    logic               last1_reg, last2_reg, last_reg;
    logic signed [33:0] rsl_reg, rcl_reg;
    logic signed [16:0] so1_reg, co1_reg;
    logic signed [50:0] xp_reg, zp_reg;
    logic signed [18:0] yq_reg;
    logic signed [16:0] x_reg, y_reg, z_reg;

    logic               en, avail, fin, load;
    logic [2:0]         k_end;
    logic [1:0]         off;
    logic signed [16:0] rad_s;
    logic signed [16:0] sl, cl, so, co;
    logic signed [33:0] ysum;
    logic signed [50:0] xsum, zsum;
    logic signed [20:0] xsh, zsh;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem_s[wptr_reg[BUF_AW-1:0]][wr.slot] <= wr.s;
            mem_c[wptr_reg[BUF_AW-1:0]][wr.slot] <= wr.c;
            if (wr.slot == 2'd3)
                mem_kind[wptr_reg[BUF_AW-1:0]] <= wr.kind;
        end
    end

    assign en    = !out_valid_reg || m_tready;
    assign avail = wptr_reg != rptr_reg;
    assign k_end = (row_kind_reg == KIND_MID) ? 3'd5 : 3'd2;
    assign fin   = active_reg && en && (k_reg == k_end);
    assign load  = avail && (!active_reg || fin);
    assign taken = load;

    always_comb
    begin
        wptr_next   = wptr_reg;
        rptr_next   = rptr_reg;
        active_next = active_reg;
        k_next      = k_reg;
        if (wr.we && wr.slot == 2'd3)
            wptr_next = wptr_reg + 1'b1;
        if (load)
            rptr_next = rptr_reg + 1'b1;
        if (load || fin)
            k_next = 3'd0;
        else if (active_reg && en)
            k_next = k_reg + 3'd1;
        if (load)
            active_next = 1'b1;
        else if (fin)
            active_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            active_reg    <= 1'b0;
            k_reg         <= 3'd0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wptr_reg   <= wptr_next;
            rptr_reg   <= rptr_next;
            active_reg <= active_next;
            k_reg      <= k_next;
            if (en)
            begin
                v1_reg        <= active_reg;
                v2_reg        <= v1_reg;
                out_valid_reg <= v2_reg;
            end
        end
    end

    // Pick the stack and slice rows of this vertex
    always_comb
    begin
        off   = pat_off(row_kind_reg, k_reg);
        sl    = row_s_reg[{1'b0, off[1]}];
        cl    = row_c_reg[{1'b0, off[1]}];
        so    = row_s_reg[{1'b1, off[0]}];
        co    = row_c_reg[{1'b1, off[0]}];
        rad_s = $signed({1'b0, radius});
        ysum  = rcl_reg + 34'sd16384;
        xsum  = xp_reg + 51'sd536870912;
        zsum  = zp_reg + 51'sd536870912;
        xsh   = 21'(xsum >>> 30);
        zsh   = 21'(zsum >>> 30);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int j = 0; j < 4; j++)
            begin
                row_s_reg[j] <= mem_s[rptr_reg[BUF_AW-1:0]][j];
                row_c_reg[j] <= mem_c[rptr_reg[BUF_AW-1:0]][j];
            end
            row_kind_reg <= mem_kind[rptr_reg[BUF_AW-1:0]];
        end
        if (en)
        begin
            rsl_reg   <= rad_s * sl;
            rcl_reg   <= rad_s * cl;
            so1_reg   <= so;
            co1_reg   <= co;
            last1_reg <= (k_reg == k_end);
            xp_reg    <= rsl_reg * so1_reg;
            zp_reg    <= rsl_reg * co1_reg;
            yq_reg    <= 19'(ysum >>> 15);
            last2_reg <= last1_reg;
            x_reg     <= sat_coord(36'(xsh));
            y_reg     <= sat_coord(36'(yq_reg));
            z_reg     <= sat_coord(36'(zsh));
            last_reg  <= last2_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, z_reg, y_reg, x_reg};
    assign m_tlast  = last_reg;

endmodule

>>> rtl/uv_sphere_tessellator.sv
// ----------------------------------------------------------------------------
// uv_sphere_tessellator
// Triangle vertices of one latitude/longitude cell of a UV sphere.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat on s_*: stack index and slice index of one cell.
//   Output beats on m_*: the cell's vertices, three for the first and last
//   stack, six otherwise, one per beat; m_tlast marks the cell's final one.
//   cfg_we/cfg_index/cfg_data write radius, stack count, latitude and
//   longitude step; write them only while the block is idle.
// Timing:
//   Each cell needs four angles (two latitude, two longitude) fed one per
//   cycle into a 24-cell CORDIC chain, so the next cell is taken no sooner
//   than the last angle of the current one is issued; the output side drains
//   one vertex per cycle while m_tready is high.
// Reset:
//   Registers return to radius 1.0, 8 stacks, steps of 1/16 and 1/8 turn;
//   the chain and the buffer come up empty.
// Stall:
//   A stalled m_tready holds the output pipe; the chain keeps running into
//   an 8-cell buffer and s_tready drops once 8 cells are in flight.
// ----------------------------------------------------------------------------
module uv_sphere_tessellator
    import uvs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // stack_index[7:0], slice_index[15:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // x_coord[16:0], y_coord[33:17], z_coord[50:34], zero pad
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_STACKS = 2'd1;
    localparam logic [1:0] REG_LAT    = 2'd2;
    localparam logic [1:0] REG_LON    = 2'd3;

    logic [15:0]        radius_reg;
    logic [8:0]         stack_count_reg;
    logic [15:0]        lat_step_reg;
    logic [15:0]        lon_step_reg;

    logic               busy_reg, busy_next;
    logic [1:0]         slot_reg, slot_next;
    logic [7:0]         p_reg, q_reg;
    kind_t              kind_reg, kind_next;
    logic [BUF_AW:0]    flight_reg, flight_next;
    cord_t              feed_reg, feed_next;

    cord_t              chain [CORDIC_STEPS+1];
    sc_wr_t             wr;
    logic               taken;
    logic               acc;
    logic               is_last;
    logic [7:0]         p_in;
    logic [8:0]         idx;
    logic [15:0]        step;
    logic [24:0]        prod;
    logic signed [33:0] cq_full, sq_full;
    logic signed [16:0] cq, sq;

    assign p_in     = s_tdata[7:0];
    assign s_tready = (!busy_reg || slot_reg == 2'd3) && (flight_reg < (BUF_AW+1)'(BUF_DEPTH));
    assign acc      = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg      <= 16'd256;
            stack_count_reg <= 9'd8;
            lat_step_reg    <= 16'd4096;
            lon_step_reg    <= 16'd8192;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RADIUS: radius_reg      <= cfg_data;
                REG_STACKS: stack_count_reg <= cfg_data[8:0];
                REG_LAT:    lat_step_reg    <= cfg_data;
                REG_LON:    lon_step_reg    <= cfg_data;
                default:    radius_reg      <= radius_reg;
            endcase
        end
    end

    // Classify the cell on the input beat
    always_comb
    begin
        is_last = (stack_count_reg != 9'd0)
               && (stack_count_reg <= 9'(MAX_DIVISIONS))
               && ({1'b0, p_in} == stack_count_reg - 9'd1);
        if (p_in == 8'd0)
            kind_next = KIND_FIRST;
        else if (is_last)
            kind_next = KIND_LAST;
        else
            kind_next = KIND_MID;
    end

    // Issue four angles per cell: p, p+1 on latitude, q, q+1 on longitude
    always_comb
    begin
        unique case (slot_reg)
            2'd0:    idx = {1'b0, p_reg};
            2'd1:    idx = {1'b0, p_reg} + 9'd1;
            2'd2:    idx = {1'b0, q_reg};
            default: idx = {1'b0, q_reg} + 9'd1;
        endcase
        step = slot_reg[1] ? lon_step_reg : lat_step_reg;
        prod = idx * step;
        feed_next.valid = busy_reg;
        feed_next.x     = CORDIC_GAIN;
        feed_next.y     = '0;
        feed_next.z     = $signed({2'b00, prod[ANGLE_BITS-3:0], (32-ANGLE_BITS)'(0)});
        feed_next.quad  = prod[ANGLE_BITS-1:ANGLE_BITS-2];
        feed_next.slot  = slot_reg;
        feed_next.kind  = kind_reg;

        busy_next = busy_reg;
        slot_next = slot_reg;
        if (acc)
        begin
            busy_next = 1'b1;
            slot_next = 2'd0;
        end
        else if (busy_reg)
        begin
            slot_next = slot_reg + 2'd1;
            if (slot_reg == 2'd3)
                busy_next = 1'b0;
        end

        flight_next = flight_reg;
        if (acc && !taken)
            flight_next = flight_reg + 1'b1;
        else if (!acc && taken)
            flight_next = flight_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            slot_reg   <= 2'd0;
            flight_reg <= '0;
            feed_reg   <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            slot_reg   <= slot_next;
            flight_reg <= flight_next;
            feed_reg   <= feed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            p_reg    <= s_tdata[7:0];
            q_reg    <= s_tdata[15:8];
            kind_reg <= kind_next;
        end
    end

    assign chain[0] = feed_reg;

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cell
        uvs_cordic_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .stage (5'(g)),
            .cin   (chain[g]),
            .cout  (chain[g+1])
        );
    end

    // Round to Q1.15 and fold the quadrant back in
    always_comb
    begin
        cq_full = (chain[CORDIC_STEPS].x + 34'sd16384) >>> 15;
        sq_full = (chain[CORDIC_STEPS].y + 34'sd16384) >>> 15;
        cq      = cq_full[16:0];
        sq      = sq_full[16:0];
        wr.we   = chain[CORDIC_STEPS].valid;
        wr.slot = chain[CORDIC_STEPS].slot;
        wr.kind = chain[CORDIC_STEPS].kind;
        case (chain[CORDIC_STEPS].quad)
            2'd0:
            begin
                wr.c = cq;
                wr.s = sq;
            end
            2'd1:
            begin
                wr.c = -sq;
                wr.s = cq;
            end
            2'd2:
            begin
                wr.c = -cq;
                wr.s = -sq;
            end
            default:
            begin
                wr.c = sq;
                wr.s = -cq;
            end
        endcase
    end

    uvs_vertex_unit u_vertex (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .radius   (radius_reg),
        .taken    (taken),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> rtl/uvs_checker.sv
// ----------------------------------------------------------------------------
// uvs_checker
// Port-level checks of the UV sphere tessellator, bound to the top level.
// ----------------------------------------------------------------------------
module uvs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tlast
);

    // A stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // Four angles are issued per cell, so no input beat follows right away
    a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input beat taken during angle issue");

    a_x_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[16:0] != 17'h10000)
        else $error("x_coord out of saturation range");

    a_yz_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[33:17] != 17'h10000 && m_tdata[50:34] != 17'h10000)
        else $error("y_coord or z_coord out of saturation range");

endmodule

bind uv_sphere_tessellator uvs_checker u_checker (.*);
